// File: rtl/mac_text_to_magic_packet_unit_defines.svh
// Assertion macros used by mtmp_back.sv.
`ifndef MAC_TEXT_TO_MAGIC_PACKET_UNIT_DEFINES_SVH
`define MAC_TEXT_TO_MAGIC_PACKET_UNIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define MTMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define MTMP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/mtmp_pkg.sv
package mtmp_pkg;

  localparam int unsigned AddrW          = 48;
  localparam int unsigned PosW           = 5;
  localparam int unsigned RepeatCountDef = 16;
  localparam int unsigned QueueDepthDef  = 2;

  localparam logic [PosW-1:0] TextLen = 5'd17;
  localparam logic [PosW-1:0] PosSat  = 5'd18;

  localparam logic [7:0] CharColon  = 8'h3A;
  localparam logic [7:0] CharHyphen = 8'h2D;

  localparam logic [AddrW-1:0] AllOnes = {AddrW{1'b1}};

  typedef struct packed {
    logic             bad;
    logic [AddrW-1:0] addr;
  } job_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_status_t;

endpackage

// File: rtl/mtmp_front.sv
module mtmp_front import mtmp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          character_i,
  input  logic                text_end_i,
  input  queue_status_t       q_status_i,
  output logic                push_o,
  output job_t                job_o
);

  logic [PosW-1:0]  pos_q, pos_d;
  logic             err_q, err_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic             is_sep;
  logic             hex_ok;
  logic [3:0]       nib;
  logic             accept;

  always_comb begin
    hex_ok = 1'b1;
    nib    = 4'd0;
    if (character_i >= 8'h30 && character_i <= 8'h39) begin
      nib = 4'(character_i - 8'h30);
    end else if (character_i >= 8'h61 && character_i <= 8'h66) begin
      nib = 4'(character_i - 8'h57);
    end else if (character_i >= 8'h41 && character_i <= 8'h46) begin
      nib = 4'(character_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign is_sep = pos_q inside {5'd2, 5'd5, 5'd8, 5'd11, 5'd14};

  always_comb begin
    err_d  = err_q;
    pos_d  = pos_q;
    addr_d = addr_q;
    if (pos_q >= TextLen) begin
      err_d = 1'b1;
    end else if (is_sep) begin
      if (character_i != CharColon && character_i != CharHyphen) err_d = 1'b1;
    end else if (!hex_ok) begin
      err_d = 1'b1;
    end else begin
      addr_d = {addr_q[AddrW-5:0], nib};
    end
    if (pos_q < PosSat) pos_d = pos_q + 5'd1;
  end

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && text_end_i;
  assign job_o.bad  = err_d || (pos_d != TextLen);
  assign job_o.addr = addr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      err_q  <= 1'b0;
      addr_q <= '0;
    end else if (accept) begin
      if (text_end_i) begin
        pos_q  <= '0;
        err_q  <= 1'b0;
        addr_q <= '0;
      end else begin
        pos_q  <= pos_d;
        err_q  <= err_d;
        addr_q <= addr_d;
      end
    end
  end

endmodule

// File: rtl/mtmp_queue.sv
module mtmp_queue import mtmp_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  job_t          job_i,
  input  logic          pop_i,
  output job_t          job_o,
  output queue_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign status_o.not_empty = (cnt_q != '0);
  assign status_o.full      = (cnt_q == CntW'(Depth));
  assign do_push            = push_i && !status_o.full;
  assign do_pop             = pop_i && status_o.not_empty;
  assign job_o              = mem_q[rd_q];

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) r = '0;
    else r = p + PtrW'(1);
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= next_ptr(wr_q);
      if (do_pop) rd_q <= next_ptr(rd_q);
      if (do_push && !do_pop) cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

// File: rtl/mtmp_back.sv
`include "mac_text_to_magic_packet_unit_defines.svh"

module mtmp_back import mtmp_pkg::*; #(
  parameter int unsigned RepeatCount = RepeatCountDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  queue_status_t    q_status_i,
  input  job_t             job_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [AddrW-1:0] payload_word_o,
  output logic             word_last_o,
  output logic             status_o
);

  localparam int unsigned CntW = $clog2(RepeatCount + 1);

  logic [CntW-1:0]  cnt_q;
  logic             out_valid_q;
  logic [AddrW-1:0] word_q;
  logic             last_q, status_q;
  logic             load;
  logic             is_last;
  logic [AddrW-1:0] word_d;

  assign load    = q_status_i.not_empty && (!out_valid_q || out_ready_i);
  assign is_last = job_i.bad || (cnt_q == CntW'(RepeatCount));
  assign pop_o   = load && is_last;

  always_comb begin
    if (job_i.bad) word_d = '0;
    else if (cnt_q == '0) word_d = AllOnes;
    else word_d = job_i.addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        cnt_q       <= is_last ? '0 : cnt_q + CntW'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q   <= word_d;
      last_q   <= is_last;
      status_q <= job_i.bad;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign payload_word_o = word_q;
  assign word_last_o    = last_q;
  assign status_o       = status_q;

  `MTMP_ASSERT(bad_word_zero_a, (out_valid_q && status_q) |-> (last_q && word_q == '0), "bad result not zero/last")
  `MTMP_ASSERT_NEVER(cnt_overrun_a, cnt_q > CntW'(RepeatCount), "word counter overrun")
  `MTMP_ASSERT_NEVER(bad_job_advanced_a, q_status_i.not_empty && job_i.bad && cnt_q != '0, "bad request advanced counter")

endmodule

// File: rtl/mac_text_to_magic_packet_unit.sv
// Wake-on-LAN magic packet builder. Address text enters one character per request
// on the input channel; text_end_i marks the final character. On the final
// character a valid 17-character address yields 1 + REPEAT_COUNT result words
// (all-ones, then the address), one per cycle while the output is ready; any
// other text yields one result with status 1 and a zero word. Finished texts
// wait in a two-entry queue between the character parser and the word
// sequencer, so the input stalls only when that queue is full, i.e. when two
// completed texts are still being sent.
module mac_text_to_magic_packet_unit import mtmp_pkg::*; #(
  parameter int unsigned REPEAT_COUNT = RepeatCountDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       character_i,
  input  logic             text_end_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [AddrW-1:0] payload_word_o,
  output logic             word_last_o,
  output logic             status_o
);

  queue_status_t q_status;
  job_t          push_job, head_job;
  logic          push, pop;

  mtmp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .character_i (character_i),
    .text_end_i  (text_end_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .job_o       (push_job)
  );

  mtmp_queue #(
    .Depth (QueueDepthDef)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .job_o    (head_job),
    .status_o (q_status)
  );

  mtmp_back #(
    .RepeatCount (REPEAT_COUNT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .job_i          (head_job),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .payload_word_o (payload_word_o),
    .word_last_o    (word_last_o),
    .status_o       (status_o)
  );

endmodule
